// ===== hw/rtl/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, codes, widths and helpers for the pure pursuit steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int POS_W  = 24;
	localparam int QUAT_W = 16;
	localparam int DIST_W = 23;
	localparam int SPD_W  = 15;
	localparam int ANG_W  = 16;
	localparam int DIF_W  = 25;
	localparam int MUL_W  = 27;
	localparam int PROD_W = 54;
	localparam int SQD_W  = 46;
	localparam int D2_W   = 50;
	localparam int REM_W  = 51;
	localparam int DIV_W  = 56;
	localparam int SQ_W   = 38;
	localparam int ROOT_W = 19;
	localparam int TRIG_W = 21;
	localparam int ACC_W  = 34;
	localparam int CACC_W = 33;
	localparam int CNT_W  = 6;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_ODOM   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_TRACK   = 2'd0,
		ST_NO_PATH = 2'd1,
		ST_GOAL    = 2'd2,
		ST_CLOSE   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_LOOKAHEAD = 2'd0,
		REG_GOAL_TOL  = 2'd1,
		REG_CRUISE    = 2'd2,
		REG_MAX_TURN  = 2'd3
	} reg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_TOL,
		S_LA,
		S_RDW,
		S_FETCH,
		S_D0,
		S_D1,
		S_D2,
		S_CMP,
		S_Q0,
		S_Q1,
		S_Q2,
		S_Q3,
		S_Q4,
		S_Q5,
		S_Q6,
		S_Q7,
		S_Q8,
		S_SQRT,
		S_Y0,
		S_Y1,
		S_Y2,
		S_DIVSET,
		S_DIV,
		S_DIVEND,
		S_W0,
		S_W1,
		S_DONE
	} state_t;

	// Q.28 to Q.14, round half away from zero
	function automatic logic signed [TRIG_W-1:0] rnd14(input logic signed [35:0] v);
		logic [35:0] mag;
		logic [35:0] q;
		mag = v[35] ? 36'(-v) : 36'(v);
		q   = (mag + 36'd8192) >> 14;
		return v[35] ? -TRIG_W'(q) : TRIG_W'(q);
	endfunction

endpackage

// ===== hw/rtl/pure_pursuit_steering.sv =====
// ----------------------------------------------------------------------------
// pure_pursuit_steering
// Waypoint store plus a pure pursuit steering solver. Clear and append
// transfers are handled as they are accepted. An odometry transfer runs a
// sequencer around one shared 27x27 multiplier, a bit-serial square root and
// a restoring divider: the goal check, then for each waypoint scanned one
// memory read and two squares, the yaw terms, the square root, the lateral
// offset, two divisions and posting the result. When the goal is reached the
// solve ends after the goal check, and with no path the sequencer goes
// straight to posting the result. The input is not ready while an odometry
// update is in progress; a finished result sits in the output register until
// it is taken.
// ----------------------------------------------------------------------------
module pure_pursuit_steering
	import pps_pkg::*;
#(
	parameter int MAX_WAYPOINTS = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [1:0]               cfg_index,
	input  logic [DIST_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               action,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [QUAT_W-1:0] quat_x,
	input  logic signed [QUAT_W-1:0] quat_y,
	input  logic signed [QUAT_W-1:0] quat_z,
	input  logic signed [QUAT_W-1:0] quat_w,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [SPD_W-1:0]         linear_cmd,
	output logic signed [ANG_W-1:0]  angular_cmd,
	output logic [1:0]               status
);

	localparam int AW = $clog2(MAX_WAYPOINTS);
	localparam int CW = $clog2(MAX_WAYPOINTS + 1);

	state_t state_q, state_d;

	logic [DIST_W-1:0] la_q, tol_q;
	logic [SPD_W-1:0]  cs_q, mtr_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     idx_q, last_idx;

	logic [2*POS_W-1:0] wp_mem [MAX_WAYPOINTS];
	logic [2*POS_W-1:0] rdata_q;
	logic               wr_en;

	logic signed [POS_W-1:0]  px_q, py_q;
	logic signed [QUAT_W-1:0] qx_q, qy_q, qz_q, qw_q;

	logic signed [MUL_W-1:0]  ma, mb;
	logic signed [PROD_W-1:0] prod_q;

	logic [SQD_W-1:0]        tol2_q, la2_q;
	logic [D2_W-1:0]         d2_q;
	logic signed [DIF_W-1:0] dx_q, dy_q, dx_new, dy_new;
	logic                    scan_q;

	logic signed [ACC_W-1:0]  s_acc_q;
	logic [CACC_W-1:0]        c_acc_q;
	logic signed [TRIG_W-1:0] s14_q, c14_q;
	logic [SQ_W-1:0]          sq_q, root_q, bit_q, root_bit, root_nxt;
	logic [ROOT_W-1:0]        r_q;

	logic signed [DIV_W-1:0] num_q;
	logic [DIV_W-1:0]        num_mag, dvd_q, quo_q;
	logic [D2_W-1:0]         den_q, den_sel;
	logic [REM_W-1:0]        rem_q, trial;
	logic [CNT_W-1:0]        div_cnt_q;
	logic                    neg_q, div2_q;
	logic signed [MUL_W-1:0] yl_q;
	logic [SPD_W-1:0]        wmag;

	logic [SPD_W-1:0]        res_lin_q;
	logic signed [ANG_W-1:0] res_ang_q;
	status_t                 res_status_q;

	logic                    out_valid_q;
	logic [SPD_W-1:0]        linear_q;
	logic signed [ANG_W-1:0] angular_q;
	status_t                 status_q;

	logic in_xfer, sel_hit;

	assign in_ready    = (state_q == S_IDLE);
	assign in_xfer     = in_valid && in_ready;
	assign out_valid   = out_valid_q;
	assign linear_cmd  = linear_q;
	assign angular_cmd = angular_q;
	assign status      = status_q;

	assign last_idx = AW'(cnt_q - CW'(1));
	assign wr_en    = in_xfer && (action_t'(action) == ACT_APPEND)
		&& (cnt_q != CW'(MAX_WAYPOINTS));
	assign dx_new   = DIF_W'($signed(rdata_q[2*POS_W-1:POS_W])) - DIF_W'(px_q);
	assign dy_new   = DIF_W'($signed(rdata_q[POS_W-1:0])) - DIF_W'(py_q);
	assign sel_hit  = ({4'b0, la2_q} <= d2_q) || (idx_q == last_idx);
	assign root_bit = root_q + bit_q;
	assign root_nxt = (sq_q >= root_bit) ? ((root_q >> 1) + bit_q) : (root_q >> 1);
	assign num_mag  = num_q[DIV_W-1] ? DIV_W'(-num_q) : DIV_W'(num_q);
	assign den_sel  = div2_q ? d2_q : D2_W'(r_q);
	assign trial    = {rem_q[REM_W-2:0], dvd_q[DIV_W-1]};
	assign wmag     = (quo_q > DIV_W'(mtr_q)) ? mtr_q : quo_q[SPD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ma      = '0;
		mb      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer && action_t'(action) == ACT_ODOM) begin
					state_d = (cnt_q == '0) ? S_DONE : S_TOL;
				end
			end
			S_TOL: begin
				ma      = MUL_W'(tol_q);
				mb      = MUL_W'(tol_q);
				state_d = S_LA;
			end
			S_LA: begin
				ma      = MUL_W'(la_q);
				mb      = MUL_W'(la_q);
				state_d = S_D0;
			end
			S_RDW:   state_d = S_FETCH;
			S_FETCH: state_d = S_D0;
			S_D0: begin
				ma      = MUL_W'(dx_q);
				mb      = MUL_W'(dx_q);
				state_d = S_D1;
			end
			S_D1: begin
				ma      = MUL_W'(dy_q);
				mb      = MUL_W'(dy_q);
				state_d = S_D2;
			end
			S_D2: state_d = S_CMP;
			S_CMP: begin
				if (!scan_q) begin
					state_d = (d2_q <= D2_W'(tol2_q)) ? S_DONE : S_RDW;
				end else if (sel_hit) begin
					state_d = (dx_q == '0 && dy_q == '0) ? S_DONE : S_Q0;
				end else begin
					state_d = S_RDW;
				end
			end
			S_Q0: begin
				ma      = MUL_W'(qw_q);
				mb      = MUL_W'(qz_q);
				state_d = S_Q1;
			end
			S_Q1: begin
				ma      = MUL_W'(qx_q);
				mb      = MUL_W'(qy_q);
				state_d = S_Q2;
			end
			S_Q2: begin
				ma      = MUL_W'(qy_q);
				mb      = MUL_W'(qy_q);
				state_d = S_Q3;
			end
			S_Q3: begin
				ma      = MUL_W'(qz_q);
				mb      = MUL_W'(qz_q);
				state_d = S_Q4;
			end
			S_Q4: state_d = S_Q5;
			S_Q5: state_d = S_Q6;
			S_Q6: begin
				if (s14_q == '0 && c14_q == '0) begin
					state_d = S_Y0;
				end else begin
					ma      = MUL_W'(c14_q);
					mb      = MUL_W'(c14_q);
					state_d = S_Q7;
				end
			end
			S_Q7: begin
				ma      = MUL_W'(s14_q);
				mb      = MUL_W'(s14_q);
				state_d = S_Q8;
			end
			S_Q8: state_d = S_SQRT;
			S_SQRT: begin
				if (bit_q[0]) begin
					state_d = S_Y0;
				end
			end
			S_Y0: begin
				ma      = MUL_W'(dy_q);
				mb      = MUL_W'(c14_q);
				state_d = S_Y1;
			end
			S_Y1: begin
				ma      = MUL_W'(dx_q);
				mb      = MUL_W'(s14_q);
				state_d = S_Y2;
			end
			S_Y2:     state_d = S_DIVSET;
			S_DIVSET: state_d = S_DIV;
			S_DIV: begin
				if (div_cnt_q == '0) begin
					state_d = S_DIVEND;
				end
			end
			S_DIVEND: state_d = div2_q ? S_DONE : S_W0;
			S_W0: begin
				ma      = MUL_W'(cs_q);
				mb      = yl_q;
				state_d = S_W1;
			end
			S_W1: state_d = S_DIVSET;
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			la_q  <= DIST_W'(4096);
			tol_q <= DIST_W'(410);
			cs_q  <= SPD_W'(2048);
			mtr_q <= SPD_W'(4096);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LOOKAHEAD: la_q  <= cfg_data;
				REG_GOAL_TOL:  tol_q <= cfg_data;
				REG_CRUISE:    cs_q  <= cfg_data[SPD_W-1:0];
				REG_MAX_TURN:  mtr_q <= cfg_data[SPD_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_xfer && action_t'(action) == ACT_CLEAR) begin
			cnt_q <= '0;
		end else if (wr_en) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			wp_mem[cnt_q[AW-1:0]] <= {pos_x, pos_y};
		end
		rdata_q <= wp_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			linear_q  <= res_lin_q;
			angular_q <= res_ang_q;
			status_q  <= res_status_q;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		unique case (state_q)
			S_IDLE: begin
				px_q         <= pos_x;
				py_q         <= pos_y;
				qx_q         <= quat_x;
				qy_q         <= quat_y;
				qz_q         <= quat_z;
				qw_q         <= quat_w;
				idx_q        <= last_idx;
				scan_q       <= 1'b0;
				div2_q       <= 1'b0;
				res_lin_q    <= '0;
				res_ang_q    <= '0;
				res_status_q <= ST_NO_PATH;
			end
			S_LA: begin
				tol2_q <= prod_q[SQD_W-1:0];
				dx_q   <= dx_new;
				dy_q   <= dy_new;
			end
			S_FETCH: begin
				dx_q <= dx_new;
				dy_q <= dy_new;
			end
			S_D0: begin
				if (!scan_q) begin
					la2_q <= prod_q[SQD_W-1:0];
				end
			end
			S_D1: d2_q <= prod_q[D2_W-1:0];
			S_D2: d2_q <= d2_q + prod_q[D2_W-1:0];
			S_CMP: begin
				if (!scan_q) begin
					res_status_q <= ST_GOAL;
					idx_q        <= '0;
					scan_q       <= 1'b1;
				end else begin
					res_status_q <= ST_CLOSE;
					if (!sel_hit) begin
						idx_q <= idx_q + AW'(1);
					end
				end
			end
			S_Q1: s_acc_q <= ACC_W'(prod_q);
			S_Q2: s_acc_q <= s_acc_q + ACC_W'(prod_q);
			S_Q3: begin
				c_acc_q <= prod_q[CACC_W-1:0];
				s14_q   <= rnd14({s_acc_q[ACC_W-1], s_acc_q, 1'b0});
			end
			S_Q4: c_acc_q <= c_acc_q + prod_q[CACC_W-1:0];
			S_Q5: c14_q <= rnd14(36'sh10000000 - {2'b0, c_acc_q, 1'b0});
			S_Q6: begin
				if (s14_q == '0 && c14_q == '0) begin
					c14_q <= TRIG_W'(1);
					r_q   <= ROOT_W'(1);
				end
			end
			S_Q7: sq_q <= prod_q[SQ_W-1:0];
			S_Q8: begin
				sq_q   <= sq_q + prod_q[SQ_W-1:0];
				root_q <= '0;
				bit_q  <= SQ_W'(1) << (SQ_W - 2);
			end
			S_SQRT: begin
				if (sq_q >= root_bit) begin
					sq_q <= sq_q - root_bit;
				end
				root_q <= root_nxt;
				bit_q  <= bit_q >> 2;
				r_q    <= root_nxt[ROOT_W-1:0];
			end
			S_Y1: num_q <= DIV_W'(prod_q);
			S_Y2: num_q <= num_q - DIV_W'(prod_q);
			S_DIVSET: begin
				neg_q     <= num_q[DIV_W-1];
				den_q     <= den_sel;
				dvd_q     <= num_mag + DIV_W'(den_sel >> 1);
				rem_q     <= '0;
				quo_q     <= '0;
				div_cnt_q <= CNT_W'(DIV_W - 1);
			end
			S_DIV: begin
				if (trial >= REM_W'(den_q)) begin
					rem_q <= trial - REM_W'(den_q);
					quo_q <= {quo_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[DIV_W-2:0], 1'b0};
				end
				dvd_q     <= dvd_q << 1;
				div_cnt_q <= div_cnt_q - CNT_W'(1);
			end
			S_DIVEND: begin
				if (!div2_q) begin
					yl_q <= neg_q ? -MUL_W'(quo_q) : MUL_W'(quo_q);
				end else begin
					res_lin_q    <= cs_q;
					res_ang_q    <= neg_q ? -ANG_W'(wmag) : ANG_W'(wmag);
					res_status_q <= ST_TRACK;
				end
			end
			S_W1: begin
				num_q  <= DIV_W'(prod_q) <<< 13;
				div2_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_WAYPOINTS))
		else $error("waypoint count above store depth");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> ({1'b0, idx_q} < (AW+1)'(cnt_q)))
		else $error("scan index beyond stored waypoints");

	a_idle_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_TRACK) |-> (linear_q == '0 && angular_q == '0))
		else $error("nonzero command without tracking");

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_TRACK) |->
		(angular_q <= $signed({1'b0, mtr_q}) && angular_q >= -$signed({1'b0, mtr_q})))
		else $error("turn rate outside clamp");

	a_ready_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && action_t'(action) == ACT_ODOM && cnt_q != '0) |=> !in_ready)
		else $error("input ready during odometry solve");
`endif

endmodule
